@@ hdl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometric pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

   // calibration register indexes
   localparam logic [2:0] REG_C1_SENS     = 3'd0;
   localparam logic [2:0] REG_C2_OFF      = 3'd1;
   localparam logic [2:0] REG_C3_TCS      = 3'd2;
   localparam logic [2:0] REG_C4_TCO      = 3'd3;
   localparam logic [2:0] REG_C5_TREF     = 3'd4;
   localparam logic [2:0] REG_C6_TEMPSENS = 3'd5;

   // reset values of the calibration words
   localparam logic [15:0] C1_RESET = 16'd32096;
   localparam logic [15:0] C2_RESET = 16'd29403;
   localparam logic [15:0] C3_RESET = 16'd37974;
   localparam logic [15:0] C4_RESET = 16'd17363;
   localparam logic [15:0] C5_RESET = 16'd33993;
   localparam logic [15:0] C6_RESET = 16'd27957;

   localparam int SHIFT_OFF  = 5;
   localparam int SHIFT_SENS = 7;
   localparam int SHIFT_TEMP = 23;
   localparam int SHIFT_X    = 21;
   localparam int SHIFT_P    = 15;
   localparam int TEMP_BASE  = 2000;

   // SENS is split for the D1 * SENS product
   localparam int SENS_LO_W = 18;

   typedef struct packed {
      logic [15:0] c1;
      logic [15:0] c2;
      logic [15:0] c3;
      logic [15:0] c4;
      logic [15:0] c5;
      logic [15:0] c6;
   } cal_type;

endpackage

@@ hdl/bpc_csr.sv @@
// ----------------------------------------------------------------------------
// bpc_csr
// Calibration register bank, one 16-bit word per factory coefficient.
// ----------------------------------------------------------------------------
module bpc_csr
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [2:0]  wr_index,
   input  logic [15:0] wr_data,
   output cal_type     cal
);

   cal_type cal_ff;
   cal_type cal_in;

   always_comb begin
      cal_in = cal_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_C1_SENS:     cal_in.c1 = wr_data;
            REG_C2_OFF:      cal_in.c2 = wr_data;
            REG_C3_TCS:      cal_in.c3 = wr_data;
            REG_C4_TCO:      cal_in.c4 = wr_data;
            REG_C5_TREF:     cal_in.c5 = wr_data;
            REG_C6_TEMPSENS: cal_in.c6 = wr_data;
            default:         cal_in = cal_ff;   // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '{c1: C1_RESET, c2: C2_RESET, c3: C3_RESET,
                     c4: C4_RESET, c5: C5_RESET, c6: C6_RESET};
      end else begin
         cal_ff <= cal_in;
      end
   end

   assign cal = cal_ff;

endmodule

@@ hdl/barometric_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// First-order compensation of raw pressure and temperature conversions.
// ----------------------------------------------------------------------------
// One word (D1, D2) is taken on every clock that start is high; busy is never
// asserted. Each word yields one result, shown for one
// cycle with rsp_valid high. The receiver cannot stall, so nothing is held.
// The 7-stage pipeline sustains one word per clock; stage depth is set by the
// 25x17 coefficient multiplies and by D1*SENS, done as two partial products.
// Calibration words should be written only while the pipeline is empty.
module barometric_pressure_compensation
   import bpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // input words
   input  logic               start,
   output logic               busy,
   input  logic [23:0]        req_pressure_raw,
   input  logic [23:0]        req_temperature_raw,
   // results
   output logic               rsp_valid,
   output logic signed [31:0] rsp_pressure_pa,
   output logic signed [18:0] rsp_temperature_centi,
   // calibration registers
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   cal_type cal;

   bpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cal      (cal)
   );

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   logic       accept;
   logic [6:0] valid_ff;
   logic [6:0] valid_in;

   assign accept   = start & ~busy;
   assign valid_in = {valid_ff[5:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---- stage 1: dT ----
   logic signed [24:0] dt_in, dt_ff;
   logic [23:0]        d1_s1_ff;

   assign dt_in = $signed({1'b0, req_temperature_raw}) - $signed({1'b0, cal.c5, 8'b0});

   always_ff @(posedge clock) begin
      dt_ff    <= dt_in;
      d1_s1_ff <= req_pressure_raw;
   end

   // ---- stage 2: coefficient products ----
   logic signed [16:0] c3_s, c4_s, c6_s;
   logic signed [40:0] off_prod_in, sens_prod_in, temp_prod_in;
   logic signed [40:0] off_prod_ff, sens_prod_ff, temp_prod_ff;
   logic [23:0]        d1_s2_ff;

   assign c3_s = $signed({1'b0, cal.c3});
   assign c4_s = $signed({1'b0, cal.c4});
   assign c6_s = $signed({1'b0, cal.c6});

   assign off_prod_in  = dt_ff * c4_s;
   assign sens_prod_in = dt_ff * c3_s;
   assign temp_prod_in = dt_ff * c6_s;

   always_ff @(posedge clock) begin
      off_prod_ff  <= off_prod_in;
      sens_prod_ff <= sens_prod_in;
      temp_prod_ff <= temp_prod_in;
      d1_s2_ff     <= d1_s1_ff;
   end

   // ---- stage 3: OFF, SENS, TEMP ----
   logic signed [36:0] off_in, off_s3_ff;
   logic signed [34:0] sens_in, sens_ff;
   logic signed [18:0] temp_in, temp_s3_ff;
   logic               temp_round;
   logic [23:0]        d1_s3_ff;

   assign off_in  = $signed({3'b0, cal.c2, 18'b0}) + 37'(off_prod_ff >>> SHIFT_OFF);
   assign sens_in = $signed({2'b0, cal.c1, 17'b0}) + 35'(sens_prod_ff >>> SHIFT_SENS);

   // round toward zero: bump a negative quotient with discarded bits
   assign temp_round = temp_prod_ff[40] & (|temp_prod_ff[SHIFT_TEMP-1:0]);
   assign temp_in    = 19'(temp_prod_ff >>> SHIFT_TEMP) + $signed({18'b0, temp_round})
                     + 19'(TEMP_BASE);

   always_ff @(posedge clock) begin
      off_s3_ff  <= off_in;
      sens_ff    <= sens_in;
      temp_s3_ff <= temp_in;
      d1_s3_ff   <= d1_s2_ff;
   end

   // ---- stage 4: D1 * SENS as two partial products ----
   logic [41:0]        pp_lo_in, pp_lo_ff;
   logic signed [41:0] pp_hi_in, pp_hi_ff;
   logic signed [16:0] sens_hi;
   logic signed [36:0] off_s4_ff;
   logic signed [18:0] temp_s4_ff;

   assign sens_hi  = sens_ff[34:SENS_LO_W];
   assign pp_lo_in = {18'b0, d1_s3_ff} * {24'b0, sens_ff[SENS_LO_W-1:0]};
   assign pp_hi_in = $signed({1'b0, d1_s3_ff}) * sens_hi;

   always_ff @(posedge clock) begin
      pp_lo_ff   <= pp_lo_in;
      pp_hi_ff   <= pp_hi_in;
      off_s4_ff  <= off_s3_ff;
      temp_s4_ff <= temp_s3_ff;
   end

   // ---- stage 5: combine partials ----
   logic signed [59:0] x_in, x_ff;
   logic signed [36:0] off_s5_ff;
   logic signed [18:0] temp_s5_ff;

   assign x_in = (60'(pp_hi_ff) <<< SENS_LO_W) + $signed({18'b0, pp_lo_ff});

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      off_s5_ff  <= off_s4_ff;
      temp_s5_ff <= temp_s4_ff;
   end

   // ---- stage 6: trunc(X / 2^21) - OFF ----
   logic signed [39:0] diff_in, diff_ff;
   logic               x_round;
   logic signed [18:0] temp_s6_ff;

   assign x_round = x_ff[59] & (|x_ff[SHIFT_X-1:0]);
   assign diff_in = 40'(x_ff >>> SHIFT_X) + $signed({39'b0, x_round}) - 40'(off_s5_ff);

   always_ff @(posedge clock) begin
      diff_ff    <= diff_in;
      temp_s6_ff <= temp_s5_ff;
   end

   // ---- stage 7: trunc(diff / 2^15), output word ----
   logic               p_round;
   logic signed [31:0] p_in;
   logic signed [31:0] p_ff;
   logic signed [18:0] temp_out_ff;

   assign p_round = diff_ff[39] & (|diff_ff[SHIFT_P-1:0]);
   assign p_in    = 32'(diff_ff >>> SHIFT_P) + $signed({31'b0, p_round});

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      temp_out_ff <= temp_s6_ff;
   end

   assign rsp_valid             = valid_ff[6];
   assign rsp_pressure_pa       = p_ff;
   assign rsp_temperature_centi = temp_out_ff;

endmodule
